// ----- design/tmav_pkg.sv -----
`default_nettype none

package tmav_pkg;

   localparam int MIN_FILL   = 3;
   localparam int TRIM_COUNT = 2;
   localparam int Q_BITS     = 8;
   localparam int Q_ONE      = 256;
   localparam int AVG_BITS   = 24;
   localparam int REQ_BITS   = 2;
   localparam int WLEN_BITS  = 6;
   localparam int WLEN_RESET = 8;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_PUSH   = 2'd0,
      REQ_CLEAR  = 2'd1,
      REQ_REINIT = 2'd2
   } req_code_type;

endpackage

`default_nettype wire

// ----- design/tmav_cell.sv -----
`default_nettype none

module tmav_cell #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire                           clock,
   input  wire                           load,
   input  wire signed [SAMPLE_BITS-1:0]  load_data,
   input  wire                           shift,
   input  wire signed [SAMPLE_BITS-1:0]  shift_in,
   output logic signed [SAMPLE_BITS-1:0] value
);

   logic signed [SAMPLE_BITS-1:0] store_ff;
   logic signed [SAMPLE_BITS-1:0] store_in;

   always_comb begin
      store_in = store_ff;
      if (load) begin
         store_in = load_data;
      end else if (shift) begin
         store_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   assign value = store_ff;

endmodule

`default_nettype wire

// ----- design/tmav_div.sv -----
`default_nettype none

module tmav_div #(
   parameter int NUM_BITS = 22,
   parameter int DEN_BITS = 6
) (
   input  wire                                           clock,
   input  wire                                           reset,
   input  wire                                           start,
   input  wire signed [NUM_BITS-1:0]                     num,
   input  wire        [DEN_BITS-1:0]                     den,
   output logic                                          done,
   output logic signed [NUM_BITS+tmav_pkg::Q_BITS:0]     quot
);

   import tmav_pkg::*;

   localparam int DW = NUM_BITS + Q_BITS;
   localparam int CNW = $clog2(DW + 1);

   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DW-1:0]       q_ff, q_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [CNW-1:0]      cnt_ff, cnt_in;
   logic                fin_ff, fin_in;

   logic [NUM_BITS-1:0] mag;
   logic [DEN_BITS:0]   trial;
   logic                ge;

   always_comb begin
      mag    = num[NUM_BITS-1] ? -num : num;
      trial  = {rem_ff, q_ff[DW-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      q_in   = q_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      fin_in = 1'b0;
      if (start) begin
         rem_in = '0;
         q_in   = {mag, {Q_BITS{1'b0}}};
         den_in = den;
         neg_in = num[NUM_BITS-1];
         cnt_in = CNW'(DW);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? DEN_BITS'(trial - {1'b0, den_ff}) : DEN_BITS'(trial);
         q_in   = {q_ff[DW-2:0], ge};
         cnt_in = cnt_ff - CNW'(1);
         fin_in = cnt_ff == CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         fin_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         fin_ff <= fin_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = fin_ff;
   assign quot = neg_ff ? -{1'b0, q_ff} : {1'b0, q_ff};

endmodule

`default_nettype wire

// ----- design/trimmed_moving_average_unit.sv -----
// push with three or more samples held: from accept the word runs one full turn of the
// sample ring, then the trim step, the divider start and the one-bit-a-cycle divider,
// before the result is registered
// clear, reinit, short push: accept moves to the result state, which registers the result word once the output is free
// one word at a time: next word taken once the result is registered
// reset: window empty, write position 0, window length 8; samples not cleared
`default_nettype none

module trimmed_moving_average_unit #(
   parameter int MAX_WINDOW  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire        [tmav_pkg::REQ_BITS-1:0]       req_type,
   input  wire signed [SAMPLE_BITS-1:0]              req_sample,
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output logic signed [tmav_pkg::AVG_BITS-1:0]      rsp_average,
   output logic                                      rsp_enough,
   input  wire                                       csr_valid,
   output logic                                      csr_ready,
   input  wire        [tmav_pkg::WLEN_BITS-1:0]      csr_window_len
);

   import tmav_pkg::*;

   localparam int LW = $clog2(MAX_WINDOW + 1);
   localparam int PW = $clog2(MAX_WINDOW);
   localparam int CW = (LW > WLEN_BITS) ? LW : WLEN_BITS;
   localparam int SW = SAMPLE_BITS + LW;
   localparam int DW = SW + Q_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TRIM,
      ST_START,
      ST_DIV,
      ST_RESULT
   } state_type;

   state_type                     state_ff, state_in;
   logic [WLEN_BITS-1:0]          window_len_ff, window_len_in;
   logic [PW-1:0]                 wp_ff, wp_in;
   logic                          full_ff, full_in;
   logic [LW-1:0]                 deep_ff, deep_in;
   logic [PW-1:0]                 cnt_ff, cnt_in;
   logic signed [SW-1:0]          sum_ff, sum_in;
   logic signed [SW-1:0]          trim_ff, trim_in;
   logic signed [SAMPLE_BITS-1:0] lo_ff, lo_in;
   logic signed [SAMPLE_BITS-1:0] hi_ff, hi_in;
   logic signed [AVG_BITS-1:0]    res_avg_ff, res_avg_in;
   logic                          res_enough_ff, res_enough_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [AVG_BITS-1:0]    rsp_average_ff, rsp_average_in;
   logic                          rsp_enough_ff, rsp_enough_in;

   logic [CW-1:0]                 wl_ext;
   logic [LW-1:0]                 eff_len;
   logic [LW-1:0]                 wp_inc;
   logic                          wrap;
   logic [PW-1:0]                 wp_push;
   logic                          full_push;
   logic [LW-1:0]                 deep_push;
   logic                          accept;
   logic                          push_acc;
   logic                          reinit_acc;
   logic                          shift_en;
   logic signed [SAMPLE_BITS-1:0] head;
   logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];

   logic                          div_start;
   logic                          div_done;
   logic signed [DW:0]            div_quot;

   assign accept     = req_valid && !req_stall;
   assign push_acc   = accept && (req_type == REQ_PUSH);
   assign reinit_acc = accept && (req_type == REQ_REINIT);
   assign shift_en   = state_ff == ST_SCAN;
   assign head       = cell_value[0];
   assign div_start  = state_ff == ST_START;

   // sample ring, cell 0 is the read head
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      localparam int NEXT = (i + 1) % MAX_WINDOW;
      logic load_en;
      assign load_en = (push_acc && (wp_ff == PW'(i))) || (reinit_acc && (i < MIN_FILL));
      tmav_cell #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
         .clock     (clock),
         .load      (load_en),
         .load_data (req_sample),
         .shift     (shift_en),
         .shift_in  (cell_value[NEXT]),
         .value     (cell_value[i])
      );
   end

   tmav_div #(
      .NUM_BITS(SW),
      .DEN_BITS(LW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (trim_ff),
      .den   (deep_ff - LW'(TRIM_COUNT)),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      wl_ext = CW'(window_len_ff);
      if (wl_ext < CW'(MIN_FILL)) begin
         eff_len = LW'(MIN_FILL);
      end else if (wl_ext > CW'(MAX_WINDOW)) begin
         eff_len = LW'(MAX_WINDOW);
      end else begin
         eff_len = LW'(wl_ext);
      end
      wp_inc    = LW'(wp_ff) + LW'(1);
      wrap      = wp_inc >= eff_len;
      wp_push   = wrap ? '0 : PW'(wp_inc);
      full_push = full_ff || wrap;
      deep_push = full_push ? eff_len : wp_inc;
   end

   always_comb begin
      state_in       = state_ff;
      window_len_in  = window_len_ff;
      wp_in          = wp_ff;
      full_in        = full_ff;
      deep_in        = deep_ff;
      cnt_in         = cnt_ff;
      sum_in         = sum_ff;
      trim_in        = trim_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      res_avg_in     = res_avg_ff;
      res_enough_in  = res_enough_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      rsp_enough_in  = rsp_enough_ff;

      if (csr_valid && csr_ready) begin
         window_len_in = csr_window_len;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               res_avg_in    = '0;
               res_enough_in = 1'b0;
               state_in      = ST_RESULT;
               case (req_type)
                  REQ_PUSH: begin
                     wp_in   = wp_push;
                     full_in = full_push;
                     deep_in = deep_push;
                     if (deep_push >= LW'(MIN_FILL)) begin
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_CLEAR: begin
                     wp_in      = '0;
                     full_in    = 1'b0;
                     res_avg_in = AVG_BITS'(Q_ONE);
                  end
                  REQ_REINIT: begin
                     wp_in      = (eff_len == LW'(MIN_FILL)) ? '0 : PW'(MIN_FILL);
                     full_in    = 1'b0;
                     res_avg_in = AVG_BITS'(Q_ONE);
                  end
                  default: begin
                     res_avg_in = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cnt_ff == '0) begin
               lo_in  = head;
               hi_in  = head;
               sum_in = SW'(head);
            end else if (LW'(cnt_ff) < deep_ff) begin
               if (head < lo_ff) begin
                  lo_in = head;
               end
               if (head > hi_ff) begin
                  hi_in = head;
               end
               sum_in = sum_ff + SW'(head);
            end
            if (cnt_ff == PW'(MAX_WINDOW - 1)) begin
               cnt_in   = '0;
               state_in = ST_TRIM;
            end else begin
               cnt_in = cnt_ff + PW'(1);
            end
         end
         ST_TRIM: begin
            trim_in  = sum_ff - SW'(lo_ff) - SW'(hi_ff);
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               res_avg_in    = AVG_BITS'(div_quot);
               res_enough_in = 1'b1;
               state_in      = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = res_avg_ff;
               rsp_enough_in  = res_enough_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= WLEN_BITS'(WLEN_RESET);
         wp_ff         <= '0;
         full_ff       <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         wp_ff         <= wp_in;
         full_ff       <= full_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      deep_ff        <= deep_in;
      sum_ff         <= sum_in;
      trim_ff        <= trim_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      res_avg_ff     <= res_avg_in;
      res_enough_ff  <= res_enough_in;
      rsp_average_ff <= rsp_average_in;
      rsp_enough_ff  <= rsp_enough_in;
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_enough  = rsp_enough_ff;
   assign csr_ready   = 1'b1;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

   a_scan_count_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SCAN |-> cnt_ff == '0)
      else $error("scan counter not parked outside scan");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == REQ_CLEAR |=> !full_ff && wp_ff == '0)
      else $error("clear word did not empty the window");

   a_short_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_enough |-> rsp_average == '0 || rsp_average == AVG_BITS'(Q_ONE))
      else $error("result without enough flag carries an average");

endmodule

`default_nettype wire

// ----- bench/trimmed_moving_average_unit_test.sv -----
`default_nettype none

localparam int WINDOW_SLOTS = 32;
localparam int SAMPLE_WIDTH = 16;
localparam logic [tmav_pkg::REQ_BITS-1:0] REQ_SPARE = 2'd3;

class window_average_book;
   typedef struct {
      logic signed [tmav_pkg::AVG_BITS-1:0] average;
      bit                                   enough;
   } mean_word_type;

   logic signed [SAMPLE_WIDTH-1:0]    slots[WINDOW_SLOTS];
   bit                                filled[WINDOW_SLOTS];
   int                                pos;
   bit                                full;
   logic [tmav_pkg::WLEN_BITS-1:0]    len_reg;
   mean_word_type                     expected_means[$];
   int errors, checked, pushes, averaged, clears, reinits, spares;

   function new();
      pos = 0;
      full = 0;
      len_reg = tmav_pkg::WLEN_BITS'(tmav_pkg::WLEN_RESET);
      foreach (filled[i]) filled[i] = 0;
      foreach (slots[i]) slots[i] = '0;
   endfunction

   function void set_window_len(logic [tmav_pkg::WLEN_BITS-1:0] value);
      len_reg = value;
   endfunction

   function int window_slots();
      int n;
      n = len_reg;
      if (n < tmav_pkg::MIN_FILL) n = tmav_pkg::MIN_FILL;
      if (n > WINDOW_SLOTS) n = WINDOW_SLOTS;
      return n;
   endfunction

   function int pending();
      return expected_means.size();
   endfunction

   // true when a push now would average a slot never written since reset
   function bit push_would_read_blank();
      int p;
      int deep;
      int i;
      bit f;
      p = pos + 1;
      f = full;
      if (p >= window_slots()) begin
         p = 0;
         f = 1;
      end
      deep = f ? window_slots() : p;
      if (deep < tmav_pkg::MIN_FILL) return 0;
      for (i = 0; i < deep; i++)
         if (!filled[i] && i != pos % WINDOW_SLOTS) return 1;
      return 0;
   endfunction

   function void note_request(logic [tmav_pkg::REQ_BITS-1:0] code,
                              logic signed [SAMPLE_WIDTH-1:0] value);
      mean_word_type w;
      int n;
      int deep;
      int i;
      longint sum, lo, hi, v;
      w.average = '0;
      w.enough = 0;
      n = window_slots();
      case (code)
         tmav_pkg::REQ_PUSH: begin
            pushes++;
            slots[pos % WINDOW_SLOTS] = value;
            filled[pos % WINDOW_SLOTS] = 1;
            pos++;
            if (pos >= n) begin
               pos = 0;
               full = 1;
            end
            deep = full ? n : pos;
            if (deep >= tmav_pkg::MIN_FILL) begin
               lo = slots[0];
               hi = slots[0];
               sum = 0;
               for (i = 0; i < deep; i++) begin
                  v = slots[i];
                  if (v < lo) lo = v;
                  if (v > hi) hi = v;
                  sum += v;
               end
               sum = sum - lo - hi;
               w.average = tmav_pkg::AVG_BITS'((sum * tmav_pkg::Q_ONE) /
                                               longint'(deep - tmav_pkg::TRIM_COUNT));
               w.enough = 1;
               averaged++;
            end
         end
         tmav_pkg::REQ_CLEAR: begin
            clears++;
            pos = 0;
            full = 0;
            w.average = tmav_pkg::AVG_BITS'(tmav_pkg::Q_ONE);
         end
         tmav_pkg::REQ_REINIT: begin
            reinits++;
            for (i = 0; i < tmav_pkg::MIN_FILL; i++) begin
               slots[i] = value;
               filled[i] = 1;
            end
            pos = tmav_pkg::MIN_FILL % n;
            full = 0;
            w.average = tmav_pkg::AVG_BITS'(tmav_pkg::Q_ONE);
         end
         default: spares++;
      endcase
      expected_means.push_back(w);
   endfunction

   function void check_result(logic signed [tmav_pkg::AVG_BITS-1:0] average, logic enough);
      mean_word_type w;
      if (expected_means.size() == 0) begin
         errors++;
         $error("unexpected result word: average %0d, enough %0b", average, enough);
         return;
      end
      w = expected_means.pop_front();
      checked++;
      if (average !== w.average) begin
         errors++;
         $error("average mismatch: expected %0d, got %0d", w.average, average);
      end
      if (enough !== w.enough) begin
         errors++;
         $error("enough mismatch: expected %0b, got %0b", w.enough, enough);
      end
   endfunction
endclass

module trimmed_moving_average_unit_test;
   localparam int PHASES      = 13;
   localparam int PER_PHASE   = 148;
   localparam int LONG_HOLD   = 400;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE      = 100;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic [tmav_pkg::REQ_BITS-1:0]          req_type = '0;
   logic signed [SAMPLE_WIDTH-1:0]         req_sample = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic signed [tmav_pkg::AVG_BITS-1:0]   rsp_average;
   logic                                   rsp_enough;
   logic                                   csr_valid = 1'b0;
   logic                                   csr_ready;
   logic [tmav_pkg::WLEN_BITS-1:0]         csr_window_len = '0;

   window_average_book book;
   bit calm = 0;
   bit hold_request = 0;
   int settings = 0;
   logic [tmav_pkg::WLEN_BITS-1:0] len_plan[PHASES] = '{
      6'd32, 6'd3, 6'd63, 6'd5, 6'd0, 6'd16, 6'd33, 6'd4, 6'd31, 6'd1, 6'd12, 6'd2, 6'd8
   };

   trimmed_moving_average_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_average    (rsp_average),
      .rsp_enough     (rsp_enough),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_window_len (csr_window_len)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int idle_cycles();
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         1, 2: return $signed(16'($urandom_range(0, 100))) - 16'sd50;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_item(input logic [tmav_pkg::REQ_BITS-1:0] code,
                            input logic signed [SAMPLE_WIDTH-1:0] value);
      int gap;
      gap = idle_cycles();
      if (code == tmav_pkg::REQ_PUSH && book.push_would_read_blank())
         code = tmav_pkg::REQ_CLEAR;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= code;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(code, value);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   task automatic write_window_len(input logic [tmav_pkg::WLEN_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_window_len <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      book.set_window_len(value);
      settings++;
   endtask

   // result side
   initial begin : result_sink
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         hold = idle_cycles();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            repeat (hold - 1) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         book.check_result(rsp_average, rsp_enough);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int k;
      int pick;
      logic [tmav_pkg::WLEN_BITS-1:0] len_value;
      book = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // default window of eight: short fill, extremes, every request code
      send_item(tmav_pkg::REQ_PUSH, 16'h7FFF);
      send_item(tmav_pkg::REQ_PUSH, 16'h8000);
      send_item(tmav_pkg::REQ_PUSH, 16'h0000);
      send_item(tmav_pkg::REQ_PUSH, 16'h0001);
      send_item(tmav_pkg::REQ_PUSH, 16'hFFFF);
      send_item(tmav_pkg::REQ_CLEAR, 16'h1234);
      send_item(tmav_pkg::REQ_REINIT, 16'h8000);
      send_item(tmav_pkg::REQ_PUSH, 16'h7FFF);
      send_item(tmav_pkg::REQ_PUSH, 16'h0005);
      send_item(REQ_SPARE, 16'h5A5A);

      // length below range: reinit position wraps to zero
      write_window_len(6'd0);
      send_item(tmav_pkg::REQ_REINIT, 16'sd100);
      send_item(tmav_pkg::REQ_PUSH, 16'sd7);
      send_item(tmav_pkg::REQ_PUSH, -16'sd7);
      send_item(tmav_pkg::REQ_PUSH, 16'h7FFF);

      // length above range, then shrink so the write position sits past the window
      write_window_len(6'd63);
      send_item(tmav_pkg::REQ_CLEAR, 16'h0000);
      for (k = 0; k < 6; k++)
         send_item(tmav_pkg::REQ_PUSH, (k % 2) ? 16'h8000 : 16'h7FFF);
      write_window_len(6'd4);
      send_item(tmav_pkg::REQ_PUSH, -16'sd3);
      write_window_len(6'd2);
      send_item(tmav_pkg::REQ_PUSH, 16'h8000);

      for (phase = 0; phase < PHASES; phase++) begin
         len_value = (phase == PHASES - 1) ? 6'($urandom_range(0, 63)) : len_plan[phase];
         write_window_len(len_value);
         calm = (phase % 4 == 1);
         for (k = 0; k < PER_PHASE; k++) begin
            if (phase == 2 && k == 40) hold_request = 1;
            if (phase == 6 && k == 70) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 92)
               send_item(tmav_pkg::REQ_PUSH, draw_sample());
            else if (pick < 95)
               send_item(tmav_pkg::REQ_REINIT, draw_sample());
            else if (pick < 98)
               send_item(tmav_pkg::REQ_CLEAR, draw_sample());
            else
               send_item(REQ_SPARE, draw_sample());
         end
      end
      calm = 0;

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d pushes (%0d averaged), %0d clears, %0d reinits, %0d spare codes",
               book.pushes, book.averaged, book.clears, book.reinits, book.spares);
      $display("%0d results checked over %0d window length settings, %0d mismatches",
               book.checked, settings, book.errors);
      if (book.errors == 0 && book.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

`default_nettype wire
